// ----- hdl/rme_pkg.sv -----
// ----------------------------------------------------------------------------
// rme_pkg
// Shared widths, constants and helpers for the rotation matrix to Euler
// angle converter.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int ELEM_W    = 16;   // Q2.14 matrix element
    localparam int OPND_W    = 18;   // CORDIC operand before scaling
    localparam int FRAC_IN   = 14;
    localparam int CW        = 34;   // CORDIC x, y and angle width
    localparam int ATAN_W    = 30;
    localparam int MAG_W     = 32;
    localparam int GAIN_W    = 30;
    localparam int PROD_W    = MAG_W + GAIN_W;
    localparam int SY_W      = 17;
    localparam int THR_W     = 15;
    localparam int ANG_W     = 16;
    localparam int ANG_SHIFT = 17;
    localparam int ANGLE_MAX = 25736;

    localparam int CORDIC_STEPS_DEFAULT = 16;
    localparam int CORDIC_STEPS_MAX     = 32;

    localparam logic [GAIN_W-1:0]     INV_GAIN   = 30'd652032874;
    localparam logic signed [CW-1:0]  HALF_PI_Z  = 34'sd1686629713;
    localparam logic [THR_W-1:0]      THR_RESET  = 15'd1;

    // round(atan(2^-i) * 2^30)
    localparam logic [ATAN_W-1:0] ATAN_TABLE [CORDIC_STEPS_MAX] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    // Round an angle (2^30 per radian) to Q3.13 and clamp to +/- pi.
    function automatic logic signed [ANG_W-1:0] angle_out(
        input logic signed [CW-1:0] z
    );
        logic signed [CW:0]           sum;
        logic signed [CW-ANG_SHIFT:0] r;
        logic signed [CW-ANG_SHIFT:0] lim;
        sum = $signed({z[CW-1], z}) + $signed((CW+1)'(1 << (ANG_SHIFT - 1)));
        r   = sum[CW:ANG_SHIFT];
        lim = $signed((CW-ANG_SHIFT+1)'(ANGLE_MAX));
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r[ANG_W-1:0];
    endfunction

    typedef struct packed {
        logic signed [ELEM_W-1:0] r20;
        logic signed [ELEM_W-1:0] r21;
        logic signed [ELEM_W-1:0] r22;
        logic signed [ELEM_W-1:0] r11;
        logic signed [ELEM_W-1:0] r12;
    } rme_elems_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] yaw;
        logic                    singular;
    } rme_side_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
        logic                    singular;
    } rme_result_t;

endpackage

// ----- hdl/rme_delay.sv -----
// ----------------------------------------------------------------------------
// rme_delay
// Enabled shift line that carries side data alongside a CORDIC pipeline.
// ----------------------------------------------------------------------------
module rme_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] dly_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                dly_reg[i] <= '0;
            end
        end else if (en) begin
            dly_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign q = dly_reg[DEPTH-1];

endmodule

// ----- hdl/rme_cordic.sv -----
// ----------------------------------------------------------------------------
// rme_cordic
// Pipelined vectoring CORDIC: one register stage for the quadrant fold,
// then one per iteration.
// ----------------------------------------------------------------------------
module rme_cordic #(
    parameter int STEPS = rme_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [rme_pkg::OPND_W-1:0] in_x,
    input  logic signed [rme_pkg::OPND_W-1:0] in_y,
    output logic signed [rme_pkg::CW-1:0]     out_z,
    output logic        [rme_pkg::MAG_W-1:0]  out_mag
);
    import rme_pkg::*;

    localparam int EXT = CW - OPND_W - FRAC_IN;

    logic signed [CW-1:0] x_reg [STEPS+1];
    logic signed [CW-1:0] y_reg [STEPS+1];
    logic signed [CW-1:0] z_reg [STEPS+1];
    logic                 zero_reg [STEPS+1];

    logic signed [CW-1:0] wx, wy, px_next, py_next, pz_next;

    assign wx = {{EXT{in_x[OPND_W-1]}}, in_x, {FRAC_IN{1'b0}}};
    assign wy = {{EXT{in_y[OPND_W-1]}}, in_y, {FRAC_IN{1'b0}}};

    // fold the left half plane onto the right one
    always_comb begin
        px_next = wx;
        py_next = wy;
        pz_next = '0;
        if (wx[CW-1]) begin
            if (!wy[CW-1]) begin
                px_next = wy;
                py_next = -wx;
                pz_next = HALF_PI_Z;
            end else begin
                px_next = -wy;
                py_next = wx;
                pz_next = -HALF_PI_Z;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= px_next;
            y_reg[0]    <= py_next;
            z_reg[0]    <= pz_next;
            zero_reg[0] <= (wx == '0) && (wy == '0);
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic signed [CW-1:0] ATAN_I =
            $signed({{(CW-ATAN_W){1'b0}}, ATAN_TABLE[i]});
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
            end
        end
    end

    // a zero vector gives angle 0 and magnitude 0
    assign out_z   = zero_reg[STEPS] ? '0 : z_reg[STEPS];
    assign out_mag = (zero_reg[STEPS] || x_reg[STEPS][CW-1]) ? '0
                   : x_reg[STEPS][MAG_W-1:0];

endmodule

// ----- hdl/rotation_matrix_to_euler.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler
// Roll, pitch and yaw (Z-Y-X) from seven elements of a rotation matrix.
// ----------------------------------------------------------------------------
// Fully pipelined: one request enters per clock while s_ready is high. The
// depth is set by two CORDIC pipelines in series, one stage per iteration:
// the first gives yaw and sy = sqrt(r00^2 + r10^2); sy is scaled by 1/K and
// compared with the threshold, which then picks the roll operands; pitch
// and roll run side by side in the second. A two-entry output buffer lets
// the pipeline park one more result in the skid entry while a result waits
// at m_, after which s_ready drops. cfg_ready is always high; write
// singular_threshold only while the block is idle.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler #(
    parameter int CORDIC_STEPS = rme_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // threshold write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic        [rme_pkg::THR_W-1:0]  cfg_data,
    // matrix request
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [rme_pkg::ELEM_W-1:0] s_r00,
    input  logic signed [rme_pkg::ELEM_W-1:0] s_r10,
    input  logic signed [rme_pkg::ELEM_W-1:0] s_r20,
    input  logic signed [rme_pkg::ELEM_W-1:0] s_r21,
    input  logic signed [rme_pkg::ELEM_W-1:0] s_r22,
    input  logic signed [rme_pkg::ELEM_W-1:0] s_r11,
    input  logic signed [rme_pkg::ELEM_W-1:0] s_r12,
    // angle result
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [rme_pkg::ANG_W-1:0]  m_roll,
    output logic signed [rme_pkg::ANG_W-1:0]  m_pitch,
    output logic signed [rme_pkg::ANG_W-1:0]  m_yaw,
    output logic                              m_singular
);
    import rme_pkg::*;

    localparam int LAT = CORDIC_STEPS + 1;

    logic en;

    // threshold register
    logic [THR_W-1:0] thr_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // ---- first CORDIC: yaw and magnitude of (r00, r10) ----
    logic signed [CW-1:0]    a_z;
    logic        [MAG_W-1:0] a_mag;
    rme_elems_t              elems_in, elems_a;
    logic                    v_a;

    rme_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
        .aclk    (aclk),
        .en      (en),
        .in_x    (OPND_W'(s_r00)),
        .in_y    (OPND_W'(s_r10)),
        .out_z   (a_z),
        .out_mag (a_mag)
    );

    assign elems_in = '{r20: s_r20, r21: s_r21, r22: s_r22, r11: s_r11, r12: s_r12};

    rme_delay #(.W($bits(rme_elems_t)), .DEPTH(LAT)) u_dly_elems (
        .aclk (aclk), .aresetn (aresetn), .en (en), .d (elems_in), .q (elems_a)
    );
    rme_delay #(.W(1), .DEPTH(LAT)) u_dly_v_a (
        .aclk (aclk), .aresetn (aresetn), .en (en), .d (s_valid), .q (v_a)
    );

    // ---- scale the magnitude by 1/K ----
    logic [PROD_W-1:0]    prod_reg;
    logic signed [CW-1:0] yaw_z_reg;
    rme_elems_t           elems1_reg;
    logic                 v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v_a;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= PROD_W'(a_mag) * PROD_W'(INV_GAIN);
            yaw_z_reg  <= a_z;
            elems1_reg <= elems_a;
        end
    end

    // ---- round sy, compare, pick roll operands ----
    logic [MAG_W:0]                sy_sum;
    logic [SY_W-1:0]               sy;
    logic                          sing;
    logic [SY_W-1:0]               sy_reg;
    logic signed [OPND_W-1:0]      pitch_y_reg, roll_x_reg, roll_y_reg;
    rme_side_t                     side2_reg, side_f;
    logic                          v2_reg, v_f;

    assign sy_sum = {1'b0, prod_reg[PROD_W-1:GAIN_W]} + (MAG_W+1)'(1 << (FRAC_IN - 1));
    assign sy     = sy_sum[FRAC_IN +: SY_W];
    assign sing   = sy < SY_W'(thr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            sy_reg      <= sy;
            pitch_y_reg <= -OPND_W'(elems1_reg.r20);
            if (sing) begin
                roll_x_reg <= OPND_W'(elems1_reg.r11);
                roll_y_reg <= -OPND_W'(elems1_reg.r12);
            end else begin
                roll_x_reg <= OPND_W'(elems1_reg.r22);
                roll_y_reg <= OPND_W'(elems1_reg.r21);
            end
            side2_reg.singular <= sing;
            side2_reg.yaw      <= sing ? '0 : angle_out(yaw_z_reg);
        end
    end

    // ---- second CORDIC pair: pitch and roll ----
    logic signed [CW-1:0] pitch_z, roll_z;

    rme_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .aclk    (aclk),
        .en      (en),
        .in_x    ($signed({1'b0, sy_reg})),
        .in_y    (pitch_y_reg),
        .out_z   (pitch_z),
        .out_mag ()
    );
    rme_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
        .aclk    (aclk),
        .en      (en),
        .in_x    (roll_x_reg),
        .in_y    (roll_y_reg),
        .out_z   (roll_z),
        .out_mag ()
    );

    rme_delay #(.W($bits(rme_side_t)), .DEPTH(LAT)) u_dly_side (
        .aclk (aclk), .aresetn (aresetn), .en (en), .d (side2_reg), .q (side_f)
    );
    rme_delay #(.W(1), .DEPTH(LAT)) u_dly_v_f (
        .aclk (aclk), .aresetn (aresetn), .en (en), .d (v2_reg), .q (v_f)
    );

    // ---- final rounding ----
    rme_result_t res_reg;
    logic        res_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (en) begin
            res_valid_reg <= v_f;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.roll     <= angle_out(roll_z);
            res_reg.pitch    <= angle_out(pitch_z);
            res_reg.yaw      <= side_f.yaw;
            res_reg.singular <= side_f.singular;
        end
    end

    // ---- output register plus skid entry ----
    rme_result_t out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    // advance the whole pipeline while the skid entry is free
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            // refill from skid first, else from the pipeline
            out_valid_reg  <= skid_valid_reg ? 1'b1 : res_valid_reg;
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            // hold the waiting result, park the next one
            skid_valid_reg <= res_valid_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res_reg;
        end else if (en) begin
            skid_reg <= res_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_roll     = out_reg.roll;
    assign m_pitch    = out_reg.pitch;
    assign m_yaw      = out_reg.yaw;
    assign m_singular = out_reg.singular;

    // ---- checks ----
    a_singular_yaw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_yaw == '0)
        else $error("yaw not cleared on singular result");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !s_ready)
        else $error("request taken while skid entry full");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_roll <= $signed(ANG_W'(ANGLE_MAX)))
                 && (m_roll >= -$signed(ANG_W'(ANGLE_MAX))))
        else $error("roll outside +/- pi");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_ready |=> !skid_valid_reg)
        else $error("skid entry not drained");

endmodule
